@@ hdl/phbr_pkg.sv @@
// ----------------------------------------------------------------------------
// phbr_pkg : shared definitions for the peak-hold bar renderer
// Widths, register indexes, reset values, the per-column store entry and the
// saturating fall helper.
// ----------------------------------------------------------------------------
`default_nettype none

package phbr_pkg;

  // Column count and store addressing
  localparam int COLUMNS = 128;
  localparam int ADDR_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Field widths
  localparam int COL_W    = 7;
  localparam int LEVEL_W  = 31;
  localparam int HOLD_W   = 8;
  localparam int PAGE_W   = 8;
  localparam int PAGES    = 8;
  localparam int ROWS     = PAGE_W * PAGES;
  localparam int ROW_SHIFT = 25;
  localparam int ROW_W    = LEVEL_W - ROW_SHIFT;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_BAR_FALL_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DOT_FALL_STEP = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_UPDATES  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_FLOOR  = CFG_IDX_W'(3);

  localparam logic [LEVEL_W-1:0] BAR_FALL_STEP_RST = LEVEL_W'(32'h0400_0000);
  localparam logic [LEVEL_W-1:0] DOT_FALL_STEP_RST = LEVEL_W'(32'h0080_0000);
  localparam logic [HOLD_W-1:0]  HOLD_UPDATES_RST  = HOLD_W'(64);
  localparam logic [LEVEL_W-1:0] HEIGHT_FLOOR_RST  = LEVEL_W'(32'h0200_0000);

  // One column's state
  typedef struct packed {
    logic [LEVEL_W-1:0] bar;
    logic [LEVEL_W-1:0] dot;
    logic [HOLD_W-1:0]  hold;
  } entry_t;

  // h - step, saturating at flr (also lifts anything at or below flr to flr)
  function automatic logic [LEVEL_W-1:0] fall(input logic [LEVEL_W-1:0] h,
                                              input logic [LEVEL_W-1:0] step,
                                              input logic [LEVEL_W-1:0] flr);
    logic [LEVEL_W:0] diff;
    diff = {1'b0, h} - {1'b0, step};
    if (!diff[LEVEL_W] && (diff[LEVEL_W-1:0] > flr)) begin
      return diff[LEVEL_W-1:0];
    end
    return flr;
  endfunction

endpackage

`default_nettype wire

@@ hdl/phbr_ifs.sv @@
// ----------------------------------------------------------------------------
// phbr_ifs : channel interfaces of the peak-hold bar renderer
// Level input, page-byte result and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface phbr_in_if;
  logic                          valid;
  logic                          ready;
  logic [phbr_pkg::COL_W-1:0]    column;
  logic [phbr_pkg::LEVEL_W-1:0]  level;
  modport source (output valid, column, level, input ready);
  modport sink   (input valid, column, level, output ready);
endinterface

interface phbr_out_if;
  logic                          valid;
  logic                          ready;
  logic [phbr_pkg::COL_W-1:0]    column_out;
  logic [phbr_pkg::PAGE_W-1:0]   page0;
  logic [phbr_pkg::PAGE_W-1:0]   page1;
  logic [phbr_pkg::PAGE_W-1:0]   page2;
  logic [phbr_pkg::PAGE_W-1:0]   page3;
  logic [phbr_pkg::PAGE_W-1:0]   page4;
  logic [phbr_pkg::PAGE_W-1:0]   page5;
  logic [phbr_pkg::PAGE_W-1:0]   page6;
  logic [phbr_pkg::PAGE_W-1:0]   page7;
  modport source (output valid, column_out, page0, page1, page2, page3, page4, page5,
                  page6, page7, input ready);
  modport sink   (input valid, column_out, page0, page1, page2, page3, page4, page5,
                  page6, page7, output ready);
endinterface

interface phbr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [phbr_pkg::CFG_IDX_W-1:0]   index;
  logic [phbr_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/peak_hold_bar_renderer.sv @@
// ----------------------------------------------------------------------------
// peak_hold_bar_renderer : per-column bar and falling peak-dot meter
// Raises a column's bar to its level, tracks a held peak dot, renders the
// column as eight page bytes and lets bar and dot fall afterwards.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------
//  in_ch    | in  | valid/ready   | column[7], level[31]
//  out_ch   | out | valid/ready   | column_out[7], page0..page7[8]
//  cfg_ch   | in  | valid/ready=1 | index[8], data[31]
//
//  One transaction per cycle sustained while out_ch accepts its results; the
//  store is read into the update stage as the input transaction is accepted,
//  and the update and render are registered into the output register when
//  the update stage hands off.
//  The per-column store is one synchronous RAM (one read, one write port);
//  a write to the column read in the same cycle is forwarded.
//  Reset clears a valid bit per column; an unwritten column reads as zero,
//  so there is no clearing pass.
//  in_ch.ready drops only when the update stage holds a transaction that
//  the full output register cannot take.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_hold_bar_renderer (
  input  wire         clk,
  input  wire         rst_n,
  phbr_in_if.sink     in_ch,
  phbr_out_if.source  out_ch,
  phbr_cfg_if.sink    cfg_ch
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [phbr_pkg::LEVEL_W-1:0] bar_step_r;
  logic [phbr_pkg::LEVEL_W-1:0] dot_step_r;
  logic [phbr_pkg::HOLD_W-1:0]  hold_upd_r;
  logic [phbr_pkg::LEVEL_W-1:0] floor_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_step_r <= phbr_pkg::BAR_FALL_STEP_RST;
      dot_step_r <= phbr_pkg::DOT_FALL_STEP_RST;
      hold_upd_r <= phbr_pkg::HOLD_UPDATES_RST;
      floor_r    <= phbr_pkg::HEIGHT_FLOOR_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        phbr_pkg::REG_BAR_FALL_STEP: bar_step_r <= cfg_ch.data[phbr_pkg::LEVEL_W-1:0];
        phbr_pkg::REG_DOT_FALL_STEP: dot_step_r <= cfg_ch.data[phbr_pkg::LEVEL_W-1:0];
        phbr_pkg::REG_HOLD_UPDATES:  hold_upd_r <= cfg_ch.data[phbr_pkg::HOLD_W-1:0];
        phbr_pkg::REG_HEIGHT_FLOOR:  floor_r    <= cfg_ch.data[phbr_pkg::LEVEL_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  logic s1_vld_r;   // update stage holds a transaction
  logic out_vld_r;  // output register full
  logic s1_adv;     // update stage hands off to the output register
  logic in_acc;
  logic s1_wr;      // store write for an in-range column

  logic s1_rng_r;
  logic [phbr_pkg::COL_W-1:0]   s1_col_r;
  logic [phbr_pkg::LEVEL_W-1:0] s1_lvl_r;

  assign s1_adv      = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign s1_wr       = s1_adv && s1_rng_r;

  // Column range check (all columns are in range at the default count)
  logic in_rng;
  assign in_rng = (32'(in_ch.column) < 32'(phbr_pkg::COLUMNS));

  logic [phbr_pkg::ADDR_W-1:0] rd_addr;
  logic [phbr_pkg::ADDR_W-1:0] wr_addr;
  assign rd_addr = phbr_pkg::ADDR_W'(in_ch.column);
  assign wr_addr = phbr_pkg::ADDR_W'(s1_col_r);

  // --------------------------------------------------------------------------
  // Column store: one RAM plus a valid bit per column
  // --------------------------------------------------------------------------
  phbr_pkg::entry_t stor_mem [phbr_pkg::COLUMNS];
  phbr_pkg::entry_t mem_q_r;     // registered read data
  phbr_pkg::entry_t wr_data;
  logic [phbr_pkg::COLUMNS-1:0] vld_r;
  logic vld_q_r;                 // column had been written at read time

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      stor_mem[wr_addr] <= wr_data;
    end
    if (in_acc) begin
      mem_q_r <= stor_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (s1_wr) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Forwarding: the column being written now is the one being read
  logic byp_r;
  phbr_pkg::entry_t byp_q_r;
  logic byp_hit;
  assign byp_hit = s1_wr && (s1_col_r == in_ch.column);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (in_acc) begin
      byp_r <= byp_hit;
    end else if (s1_adv) begin
      byp_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byp_q_r  <= wr_data;
      vld_q_r  <= vld_r[rd_addr];
      s1_col_r <= in_ch.column;
      s1_lvl_r <= in_ch.level;
      s1_rng_r <= in_rng;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Update stage: raise, peak capture, fall
  // --------------------------------------------------------------------------
  phbr_pkg::entry_t cur;
  logic raise;
  logic peak;
  logic [phbr_pkg::LEVEL_W-1:0] bar_sel;
  logic [phbr_pkg::LEVEL_W-1:0] dot_sel;
  logic [phbr_pkg::HOLD_W-1:0]  hold_eff;
  // fall results computed side by side, picked after the compares
  logic [phbr_pkg::LEVEL_W-1:0] bf_lvl, bf_bar, df_lvl, df_bar, df_dot, dot_fallen;

  always_comb begin
    if (byp_r) begin
      cur = byp_q_r;
    end else if (vld_q_r) begin
      cur = mem_q_r;
    end else begin
      cur = '0;
    end
  end

  assign raise   = s1_lvl_r > cur.bar;
  assign bar_sel = raise ? s1_lvl_r : cur.bar;
  assign peak    = cur.dot < bar_sel;
  assign dot_sel = peak ? bar_sel : cur.dot;
  assign hold_eff = peak ? hold_upd_r : cur.hold;

  assign bf_lvl = phbr_pkg::fall(s1_lvl_r, bar_step_r, floor_r);
  assign bf_bar = phbr_pkg::fall(cur.bar,  bar_step_r, floor_r);
  assign df_lvl = phbr_pkg::fall(s1_lvl_r, dot_step_r, floor_r);
  assign df_bar = phbr_pkg::fall(cur.bar,  dot_step_r, floor_r);
  assign df_dot = phbr_pkg::fall(cur.dot,  dot_step_r, floor_r);

  assign dot_fallen = !peak ? df_dot : (raise ? df_lvl : df_bar);

  always_comb begin
    wr_data.bar = raise ? bf_lvl : bf_bar;
    if (hold_eff == '0) begin
      // hold expired (or zero hold): dot falls this update
      wr_data.dot  = dot_fallen;
      wr_data.hold = '0;
    end else begin
      wr_data.dot  = dot_sel;
      wr_data.hold = hold_eff - phbr_pkg::HOLD_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Render: row r (1..64) lit when r <= bar row, or r equals the dot row
  // --------------------------------------------------------------------------
  logic [phbr_pkg::ROW_W-1:0] bar_row;
  logic [phbr_pkg::ROW_W-1:0] dot_row;
  logic [phbr_pkg::ROWS-1:0]  rows;

  assign bar_row = bar_sel[phbr_pkg::LEVEL_W-1:phbr_pkg::ROW_SHIFT];
  assign dot_row = dot_sel[phbr_pkg::LEVEL_W-1:phbr_pkg::ROW_SHIFT];

  always_comb begin
    for (int i = 0; i < phbr_pkg::ROWS; i++) begin
      rows[i] = s1_rng_r &&
                ((7'(i + 1) <= {1'b0, bar_row}) || (7'(i + 1) == {1'b0, dot_row}));
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [phbr_pkg::COL_W-1:0] out_col_r;
  logic [phbr_pkg::ROWS-1:0]  out_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_col_r  <= s1_col_r;
      out_rows_r <= rows;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.column_out = out_col_r;
  assign out_ch.page0      = out_rows_r[7:0];
  assign out_ch.page1      = out_rows_r[15:8];
  assign out_ch.page2      = out_rows_r[23:16];
  assign out_ch.page3      = out_rows_r[31:24];
  assign out_ch.page4      = out_rows_r[39:32];
  assign out_ch.page5      = out_rows_r[47:40];
  assign out_ch.page6      = out_rows_r[55:48];
  assign out_ch.page7      = out_rows_r[63:56];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_wr_only_on_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    s1_wr |-> (s1_vld_r && (!out_vld_r || out_ch.ready)))
    else $error("store written without a result handoff");

  a_acc_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted transaction lost before update stage");

  a_byp_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> s1_vld_r)
    else $error("forward flag set with empty update stage");

  a_byp_same_col: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && byp_hit) |=> (s1_col_r == $past(s1_col_r)))
    else $error("forwarded entry belongs to another column");

  a_reset_clears_valid: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("column valid bits not cleared by reset");

endmodule

`default_nettype wire
